@@ rtl/ow_pkg.sv @@
// shared types, phase codes and command codes for the one-wire bus master
package ow_pkg;

    localparam int unsigned TIMER_W = 10;
    localparam int unsigned PULSE_W = 6;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BIT_W   = 3;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CFGI_W  = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_RESET_LOW     = 4'd0;
    localparam logic [CFGI_W-1:0] CFG_RESET_RELEASE = 4'd1;
    localparam logic [CFGI_W-1:0] CFG_RESET_SETTLE  = 4'd2;
    localparam logic [CFGI_W-1:0] CFG_START_PULSE   = 4'd3;
    localparam logic [CFGI_W-1:0] CFG_READ_SAMPLE   = 4'd4;
    localparam logic [CFGI_W-1:0] CFG_READ_RECOVER  = 4'd5;
    localparam logic [CFGI_W-1:0] CFG_WRITE_LEAD    = 4'd6;
    localparam logic [CFGI_W-1:0] CFG_WRITE_HOLD    = 4'd7;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RST_LOW    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RST_REL    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RST_SETTLE = 4'd3;
    localparam logic [PHASE_W-1:0] PH_RST_WAIT   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_WR_LEAD    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WR_PULSE   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_WR_HOLD    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RD_PULSE   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RD_SAMPLE  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_RD_CAPTURE = 4'd10;
    localparam logic [PHASE_W-1:0] PH_RD_RECOVER = 4'd11;

    typedef struct packed {
        logic [TIMER_W-1:0] reset_low_ticks;
        logic [TIMER_W-1:0] reset_release_ticks;
        logic [TIMER_W-1:0] reset_settle_ticks;
        logic [PULSE_W-1:0] start_pulse_ticks;
        logic [TIMER_W-1:0] read_sample_ticks;
        logic [TIMER_W-1:0] read_recover_ticks;
        logic [TIMER_W-1:0] write_lead_ticks;
        logic [TIMER_W-1:0] write_hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] write_data;
        logic              line_in;
    } t_item;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ignored;
    } t_res;

endpackage

@@ rtl/ow_if.sv @@
// word channels of the one-wire bus master: command, result and configuration
interface ow_cmd_if import ow_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] write_data;
    logic              line_in;
    modport source (output valid, command, write_data, line_in, input ready);
    modport sink (input valid, command, write_data, line_in, output ready);
endinterface

interface ow_res_if import ow_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              ignored;
    modport source (output valid, drive_low, busy_res, done_res, read_data, ignored,
                    input ready);
    modport sink (input valid, drive_low, busy_res, done_res, read_data, ignored,
                  output ready);
endinterface

interface ow_cfg_if import ow_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CFGI_W-1:0]  index;
    logic [TIMER_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/one_wire_master.sv @@
// top level of the one-wire bus master: word pipeline around the phase sequencer
// a command word is registered in the input register, then stepped into the result register
// throughput: one word per cycle while the result side is not stalled; the sequencer state updates once per word
// the result register frees itself while the next word is registered; a result stall holds both
// reset (synchronous, active low): phase idle, counters and bytes cleared, timings to defaults
// configuration writes take effect on the next word and are always accepted
module one_wire_master import ow_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ow_cmd_if.sink    i_cmd,
    ow_res_if.source  o_res,
    ow_cfg_if.sink    i_cfg
);

    // input register stage
    logic  r_in_valid;
    t_item r_in;

    // result register stage
    logic  r_out_valid;
    t_res  r_out;

    t_cfg  cfg;
    t_res  seq_res;
    logic  step;

    // a word moves into the result register when it is empty or being drained
    assign step        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || step;

    ow_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ow_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (seq_res)
    );

    // input register: valid flag is control, payload is loaded on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in.command    <= i_cmd.command;
            r_in.write_data <= i_cmd.write_data;
            r_in.line_in    <= i_cmd.line_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.drive_low = r_out.drive_low;
    assign o_res.busy_res  = r_out.busy_res;
    assign o_res.done_res  = r_out.done_res;
    assign o_res.read_data = r_out.read_data;
    assign o_res.ignored   = r_out.ignored;

endmodule

@@ rtl/ow_cfg_regs.sv @@
// timing configuration registers of the one-wire bus master
module ow_cfg_regs import ow_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ow_cfg_if.sink   i_cfg,
    output t_cfg     o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks     <= 10'd450;
            r_cfg.reset_release_ticks <= 10'd60;
            r_cfg.reset_settle_ticks  <= 10'd10;
            r_cfg.start_pulse_ticks   <= 6'd1;
            r_cfg.read_sample_ticks   <= 10'd8;
            r_cfg.read_recover_ticks  <= 10'd60;
            r_cfg.write_lead_ticks    <= 10'd16;
            r_cfg.write_hold_ticks    <= 10'd40;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_RESET_LOW:     r_cfg.reset_low_ticks     <= i_cfg.data;
                CFG_RESET_RELEASE: r_cfg.reset_release_ticks <= i_cfg.data;
                CFG_RESET_SETTLE:  r_cfg.reset_settle_ticks  <= i_cfg.data;
                CFG_START_PULSE:   r_cfg.start_pulse_ticks   <= i_cfg.data[PULSE_W-1:0];
                CFG_READ_SAMPLE:   r_cfg.read_sample_ticks   <= i_cfg.data;
                CFG_READ_RECOVER:  r_cfg.read_recover_ticks  <= i_cfg.data;
                CFG_WRITE_LEAD:    r_cfg.write_lead_ticks    <= i_cfg.data;
                CFG_WRITE_HOLD:    r_cfg.write_hold_ticks    <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/ow_seq.sv @@
// bus phase sequencer: one tick or command per step
module ow_seq import ow_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_step,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [BYTE_W-1:0]  r_shift, n_shift;
    logic [BYTE_W-1:0]  r_last, n_last;

    logic [PHASE_W-1:0] cur;
    logic [TIMER_W-1:0] tick;
    logic [TIMER_W-1:0] len;
    logic [BIT_W-1:0]   bit_nx;
    logic [BYTE_W-1:0]  cap;
    logic               end_now;
    logic               ign;
    logic               drive;
    logic               fin;

    function automatic logic [TIMER_W-1:0] at_least_one(input logic [TIMER_W-1:0] v);
        return (v == '0) ? TIMER_W'(1) : v;
    endfunction

    function automatic logic [TIMER_W-1:0] phase_len(input logic [PHASE_W-1:0] p,
                                                     input t_cfg c);
        logic [TIMER_W-1:0] pulse;
        pulse = at_least_one(TIMER_W'(c.start_pulse_ticks));
        case (p)
            PH_RST_LOW:    return at_least_one(c.reset_low_ticks);
            PH_RST_REL:    return c.reset_release_ticks;
            PH_RST_SETTLE: return c.reset_settle_ticks;
            PH_WR_LEAD:    return c.write_lead_ticks;
            PH_WR_PULSE:   return pulse;
            PH_WR_HOLD:    return at_least_one(c.write_hold_ticks);
            PH_RD_PULSE:   return pulse;
            PH_RD_SAMPLE:  return c.read_sample_ticks;
            PH_RD_RECOVER: return c.read_recover_ticks;
            default:       return TIMER_W'(1);
        endcase
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_last  = r_last;
        ign     = 1'b0;
        drive   = 1'b0;
        fin     = 1'b0;
        end_now = 1'b0;

        // start command
        if (i_item.command != CMD_TICK) begin
            if (r_phase != PH_IDLE) begin
                ign = 1'b1;
            end else begin
                n_bit   = '0;
                n_timer = '0;
                case (i_item.command)
                    CMD_RESET: begin
                        n_phase = PH_RST_LOW;
                    end
                    CMD_WRITE: begin
                        n_shift = i_item.write_data;
                        n_phase = (i_cfg.write_lead_ticks == '0) ? PH_WR_PULSE : PH_WR_LEAD;
                    end
                    default: begin
                        n_shift = '0;
                        n_phase = PH_RD_PULSE;
                    end
                endcase
            end
        end

        cur    = n_phase;
        len    = phase_len(cur, i_cfg);
        tick   = n_timer + TIMER_W'(1);
        bit_nx = n_bit + BIT_W'(1);
        cap    = {i_item.line_in, n_shift[BYTE_W-1:1]};

        // spend this tick in the current phase
        if (cur != PH_IDLE) begin
            case (cur)
                PH_RST_LOW, PH_WR_PULSE, PH_RD_PULSE: drive = 1'b1;
                PH_WR_HOLD: drive = ~n_shift[0];
                default: drive = 1'b0;
            endcase
            if (cur == PH_RST_WAIT) begin
                end_now = i_item.line_in;
            end else if (tick >= len) begin
                end_now = 1'b1;
            end else begin
                n_timer = tick;
            end
        end

        // phase end action, skipping empty phases
        if (end_now) begin
            n_timer = '0;
            case (cur)
                PH_RST_LOW: begin
                    if (i_cfg.reset_release_ticks != '0) n_phase = PH_RST_REL;
                    else if (i_cfg.reset_settle_ticks != '0) n_phase = PH_RST_SETTLE;
                    else n_phase = PH_RST_WAIT;
                end
                PH_RST_REL: begin
                    n_phase = (i_cfg.reset_settle_ticks != '0) ? PH_RST_SETTLE : PH_RST_WAIT;
                end
                PH_RST_SETTLE: n_phase = PH_RST_WAIT;
                PH_RST_WAIT: begin
                    fin     = 1'b1;
                    n_phase = PH_IDLE;
                end
                PH_WR_LEAD:  n_phase = PH_WR_PULSE;
                PH_WR_PULSE: n_phase = PH_WR_HOLD;
                PH_WR_HOLD: begin
                    n_shift = {1'b0, n_shift[BYTE_W-1:1]};
                    n_bit   = bit_nx;
                    if (bit_nx == '0) begin
                        fin     = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_WR_PULSE;
                    end
                end
                PH_RD_PULSE: begin
                    n_phase = (i_cfg.read_sample_ticks != '0) ? PH_RD_SAMPLE : PH_RD_CAPTURE;
                end
                PH_RD_SAMPLE: n_phase = PH_RD_CAPTURE;
                PH_RD_CAPTURE: begin
                    n_shift = cap;
                    if (i_cfg.read_recover_ticks != '0) begin
                        n_phase = PH_RD_RECOVER;
                    end else begin
                        // empty recovery: finish the bit straight away
                        n_bit = bit_nx;
                        if (bit_nx == '0) begin
                            n_last  = cap;
                            fin     = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_RD_PULSE;
                        end
                    end
                end
                PH_RD_RECOVER: begin
                    n_bit = bit_nx;
                    if (bit_nx == '0) begin
                        n_last  = n_shift;
                        fin     = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_RD_PULSE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    assign o_res.drive_low = drive;
    assign o_res.busy_res  = (n_phase != PH_IDLE);
    assign o_res.done_res  = fin;
    assign o_res.read_data = n_last;
    assign o_res.ignored   = ign;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_last  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_last  <= n_last;
        end
    end

`ifndef SYNTH
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.done_res |=> r_phase == PH_IDLE)
        else $error("phase not idle after finishing step");
    a_ign_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.ignored |-> r_phase != PH_IDLE)
        else $error("command flagged while idle");
    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_timer == '0)
        else $error("phase timer not cleared in idle");
`endif

endmodule
